// ===== rtl/eik_pkg.sv =====
// Shared types and constants of the eikonal node update block.
// Command and status records between controller and datapath, field records.
// No dependencies.
`default_nettype none
package eik_pkg;

	localparam int TB = 32;
	localparam int FB = 16;
	localparam logic [TB-1:0] FAR = {TB{1'b1}};

	localparam int IN_W  = 264;
	localparam int OUT_W = 40;

	localparam logic [1:0] EDGE_INT  = 2'd0;
	localparam logic [1:0] EDGE_LOW  = 2'd1;
	localparam logic [1:0] EDGE_HIGH = 2'd2;

	localparam logic [1:0] REG_SP_R  = 2'd0;
	localparam logic [1:0] REG_SP_T  = 2'd1;
	localparam logic [1:0] REG_SP_P  = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	localparam logic [TB-1:0] SPACING_RESET = 32'h0001_0000;
	localparam logic [TB-1:0] LIMIT_RESET   = 32'hFFFF_FFFF;

	localparam logic [4:0] OP_NONE    = 5'd0;
	localparam logic [4:0] OP_LOAD    = 5'd1;
	localparam logic [4:0] OP_SORT    = 5'd2;
	localparam logic [4:0] OP_SKIP    = 5'd3;
	localparam logic [4:0] OP_MUL_SH0 = 5'd4;
	localparam logic [4:0] OP_ONESIDE = 5'd5;
	localparam logic [4:0] OP_SETUP   = 5'd6;
	localparam logic [4:0] OP_QD      = 5'd7;
	localparam logic [4:0] OP_KSTEP   = 5'd8;
	localparam logic [4:0] OP_RDIV    = 5'd9;
	localparam logic [4:0] OP_RSQ     = 5'd10;
	localparam logic [4:0] OP_U       = 5'd11;
	localparam logic [4:0] OP_B       = 5'd12;
	localparam logic [4:0] OP_QQ      = 5'd13;
	localparam logic [4:0] OP_P1      = 5'd14;
	localparam logic [4:0] OP_P2      = 5'd15;
	localparam logic [4:0] OP_UU      = 5'd16;
	localparam logic [4:0] OP_DD      = 5'd17;
	localparam logic [4:0] OP_PR      = 5'd18;
	localparam logic [4:0] OP_MS      = 5'd19;
	localparam logic [4:0] OP_SQRT    = 5'd20;
	localparam logic [4:0] OP_DIV2    = 5'd21;
	localparam logic [4:0] OP_CAND    = 5'd22;
	localparam logic [4:0] OP_DELIVER = 5'd23;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] idx_i;
		logic [1:0] idx_j;
		logic       n3;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic skip;
		logic gt1;
		logic k_more;
		logic fail;
		logic go3;
	} stat_t;

	typedef struct packed {
		logic [TB-1:0] r_lower;
		logic [TB-1:0] r_upper;
		logic [TB-1:0] t_lower;
		logic [TB-1:0] t_upper;
		logic [TB-1:0] p_lower;
		logic [TB-1:0] p_upper;
		logic [1:0]    edge_r;
		logic [1:0]    edge_t;
		logic [1:0]    edge_p;
		logic [TB-1:0] slowness;
		logic [TB-1:0] current_time;
	} in_t;

	typedef struct packed {
		logic [TB-1:0] spacing_radial;
		logic [TB-1:0] spacing_theta;
		logic [TB-1:0] spacing_phi;
		logic [TB-1:0] neighbour_limit;
	} cfg_t;

	typedef struct packed {
		logic [TB-1:0] new_time;
		logic          updated;
		logic          skipped;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/eikonal_upwind_node_update.sv =====
// One node at a time. The wait for a result depends on the path taken: a skipped node,
// the one-sided estimate alone, the two-axis solve, or both solves. It is set by the
// bit-serial divider (up to seven uses per node) and square root (up to two uses). The next
// request is taken the cycle after the result enters the output register. Reset clears
// control, sets spacings to 1.0 and the limit to all ones; no clearing pass. Depends on
// eik_pkg.
`default_nettype none
module eikonal_upwind_node_update (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// r_lower, r_upper, t_lower, t_upper, p_lower, p_upper, edge_r, edge_t,
	// edge_p, slowness, current_time, zero fill
	input  wire logic [263:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// new_time, updated, skipped, zero fill
	output logic [39:0]       m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import eik_pkg::*;

	in_t   req;
	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	res_t  res;
	logic  out_free;
	logic  out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	assign req.r_lower      = s_axis_tdata[31:0];
	assign req.r_upper      = s_axis_tdata[63:32];
	assign req.t_lower      = s_axis_tdata[95:64];
	assign req.t_upper      = s_axis_tdata[127:96];
	assign req.p_lower      = s_axis_tdata[159:128];
	assign req.p_upper      = s_axis_tdata[191:160];
	assign req.edge_r       = s_axis_tdata[193:192];
	assign req.edge_t       = s_axis_tdata[195:194];
	assign req.edge_p       = s_axis_tdata[197:196];
	assign req.slowness     = s_axis_tdata[229:198];
	assign req.current_time = s_axis_tdata[261:230];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spacing_radial  <= SPACING_RESET;
			cfg_q.spacing_theta   <= SPACING_RESET;
			cfg_q.spacing_phi     <= SPACING_RESET;
			cfg_q.neighbour_limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SP_R:  cfg_q.spacing_radial  <= cfg_data;
				REG_SP_T:  cfg_q.spacing_theta   <= cfg_data;
				REG_SP_P:  cfg_q.spacing_phi     <= cfg_data;
				REG_LIMIT: cfg_q.neighbour_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	eik_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	eik_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.cfg    (cfg_q),
		.stat   (stat),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_DELIVER) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DELIVER)
			out_data_q <= {6'b0, res.skipped, res.updated, res.new_time};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_deliver_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DELIVER |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwrote a pending output");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
		else $error("result both updated and skipped");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result delivered while taking a request");

endmodule
`default_nettype wire

// ===== rtl/eik_dp.sv =====
// Datapath of the eikonal node update: operand registers, shared 64x64
// multiplier built from 32x32 partial products, bit-serial divider and root.
// Depends on eik_pkg.
`default_nettype none
module eik_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire eik_pkg::cmd_t cmd,
	input  wire eik_pkg::in_t  req,
	input  wire eik_pkg::cfg_t cfg,
	output eik_pkg::stat_t     stat,
	output eik_pkg::res_t      res
);
	import eik_pkg::*;

	logic [TB-1:0] t_q [3];
	logic [TB-1:0] h_q [3];
	logic [TB-1:0] d_q [3];
	logic [TB-1:0] u_q [3];
	logic [TB-1:0] s_q, cur_q, cand_q, hm_q;
	logic          skip_q;
	logic [47:0]   q_q;
	logic [4:0]    k_q;
	logic [33:0]   a_q;
	logic [63:0]   b_q, uu_q;
	logic [127:0]  p_q, msum_q;

	logic [TB-1:0] ts [3];
	logic [TB-1:0] hs [3];
	logic [TB-1:0] tx, hx, m01, hm_c, u_new, di, dj, dd;

	logic          mul_start;
	logic [63:0]   mul_a, mul_b, ma_q, mb_q, pp_s1, pp_c;
	logic [1:0]    ppsh_s1, ppsh_c;
	logic          ppv_s1, mul_busy_q;
	logic [2:0]    mcnt_q;
	logic [127:0]  acc_q;

	logic          div_start, div_busy_q, div_ge;
	logic [65:0]   div_num, dnum_q, quo_q;
	logic [33:0]   div_den, dden_q, drem_q;
	logic [34:0]   div_sh, div_diff;
	logic [6:0]    dcnt_q;

	logic          sq_start, sq_busy_q, sq_ge;
	logic [127:0]  sq_rad, rad_q;
	logic [63:0]   root_q;
	logic [65:0]   srem_q;
	logic [67:0]   sq_sh, sq_trial, sq_diff;
	logic [6:0]    scnt_q;

	logic [63:0]   one_sum, cand_sum, x_sh;

	function automatic logic [TB-1:0] pick(input logic [TB-1:0] lo, input logic [TB-1:0] up,
		input logic [1:0] code);
		logic [TB-1:0] v;
		unique case (code)
			EDGE_INT:  v = (up < lo) ? up : lo;
			EDGE_LOW:  v = up;
			EDGE_HIGH: v = lo;
			default:   v = FAR;
		endcase
		return v;
	endfunction

	function automatic logic [TB-1:0] nz(input logic [TB-1:0] h);
		return (h == '0) ? {{(TB-1){1'b0}}, 1'b1} : h;
	endfunction

	function automatic logic [TB-1:0] sat_time(input logic [63:0] v);
		return (v >= {32'b0, FAR}) ? FAR : v[TB-1:0];
	endfunction

	always_comb begin
		tx = '0;
		hx = '0;
		for (int n = 0; n < 3; n++) begin
			ts[n] = t_q[n];
			hs[n] = h_q[n];
		end
		if (ts[0] > ts[1]) begin
			tx = ts[0]; ts[0] = ts[1]; ts[1] = tx;
			hx = hs[0]; hs[0] = hs[1]; hs[1] = hx;
		end
		if (ts[1] > ts[2]) begin
			tx = ts[1]; ts[1] = ts[2]; ts[2] = tx;
			hx = hs[1]; hs[1] = hs[2]; hs[2] = hx;
		end
		if (ts[0] > ts[1]) begin
			tx = ts[0]; ts[0] = ts[1]; ts[1] = tx;
			hx = hs[0]; hs[0] = hs[1]; hs[1] = hx;
		end
	end

	assign m01      = (h_q[1] < h_q[0]) ? h_q[1] : h_q[0];
	assign hm_c     = (cmd.n3 && h_q[2] < m01) ? h_q[2] : m01;
	assign u_new    = acc_q[62:31];
	assign di       = d_q[cmd.idx_i];
	assign dj       = d_q[cmd.idx_j];
	assign dd       = (dj >= di) ? dj - di : di - dj;
	assign one_sum  = {32'b0, t_q[0]} + {16'b0, acc_q[63:16]};
	assign x_sh     = {28'b0, quo_q[35:0]} << k_q;
	assign cand_sum = {32'b0, t_q[0]} + x_sh;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				t_q[0] <= pick(req.r_lower, req.r_upper, req.edge_r);
				t_q[1] <= pick(req.t_lower, req.t_upper, req.edge_t);
				t_q[2] <= pick(req.p_lower, req.p_upper, req.edge_p);
				h_q[0] <= nz(cfg.spacing_radial);
				h_q[1] <= nz(cfg.spacing_theta);
				h_q[2] <= nz(cfg.spacing_phi);
				s_q    <= req.slowness;
				cur_q  <= req.current_time;
				skip_q <= 1'b0;
			end
			OP_SORT: begin
				for (int n = 0; n < 3; n++) begin
					t_q[n] <= ts[n];
					h_q[n] <= hs[n];
				end
			end
			OP_SKIP:    skip_q <= 1'b1;
			OP_ONESIDE: cand_q <= sat_time(one_sum);
			OP_SETUP: begin
				hm_q   <= hm_c;
				a_q    <= '0;
				b_q    <= '0;
				msum_q <= '0;
				k_q    <= '0;
			end
			OP_QD: begin
				q_q    <= acc_q[63:16];
				d_q[0] <= '0;
				d_q[1] <= t_q[1] - t_q[0];
				d_q[2] <= cmd.n3 ? t_q[2] - t_q[0] : '0;
			end
			OP_KSTEP: begin
				q_q <= q_q >> 1;
				for (int n = 0; n < 3; n++) d_q[n] <= d_q[n] >> 1;
				k_q <= k_q + 5'd1;
			end
			OP_U: begin
				u_q[cmd.idx_i] <= u_new;
				a_q <= a_q + {2'b0, u_new};
			end
			OP_B:    b_q <= b_q + acc_q[63:0];
			OP_P2:   p_q <= {acc_q[96:0], 31'b0};
			OP_DD:   uu_q <= acc_q[63:0];
			OP_MS:   msum_q <= msum_q + acc_q;
			OP_CAND: cand_q <= sat_time(cand_sum);
			default: ;
		endcase
	end

	always_comb begin
		mul_start = 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_SH0: begin mul_a = {32'b0, s_q}; mul_b = {32'b0, h_q[0]}; end
			OP_SETUP:   begin mul_a = {32'b0, s_q}; mul_b = {32'b0, hm_c}; end
			OP_RSQ:     begin mul_a = {32'b0, quo_q[31:0]}; mul_b = {32'b0, quo_q[31:0]}; end
			OP_U:       begin mul_a = {32'b0, u_new}; mul_b = {32'b0, di}; end
			OP_QQ:      begin mul_a = {32'b0, q_q[31:0]}; mul_b = {32'b0, q_q[31:0]}; end
			OP_P1:      begin mul_a = {30'b0, a_q}; mul_b = {2'b0, acc_q[61:0]}; end
			OP_UU:      begin mul_a = {32'b0, di}; mul_b = '0; mul_a = {32'b0, u_q[cmd.idx_i]};
				mul_b = {32'b0, u_q[cmd.idx_j]}; end
			OP_DD:      begin mul_a = {32'b0, dd}; mul_b = {32'b0, dd}; end
			OP_PR:      begin mul_a = uu_q; mul_b = acc_q[63:0]; end
			default:    mul_start = 1'b0;
		endcase
	end

	always_comb begin
		pp_c   = '0;
		ppsh_c = 2'd0;
		unique case (mcnt_q[1:0])
			2'd0: begin pp_c = ma_q[31:0] * mb_q[31:0];   ppsh_c = 2'd0; end
			2'd1: begin pp_c = ma_q[31:0] * mb_q[63:32];  ppsh_c = 2'd1; end
			2'd2: begin pp_c = ma_q[63:32] * mb_q[31:0];  ppsh_c = 2'd1; end
			default: begin pp_c = ma_q[63:32] * mb_q[63:32]; ppsh_c = 2'd2; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mcnt_q     <= '0;
			ppv_s1     <= 1'b0;
		end else if (mul_start) begin
			mul_busy_q <= 1'b1;
			mcnt_q     <= '0;
			ppv_s1     <= 1'b0;
		end else if (mul_busy_q) begin
			mcnt_q <= mcnt_q + 3'd1;
			ppv_s1 <= (mcnt_q != 3'd4);
			if (mcnt_q == 3'd4) mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			ma_q  <= mul_a;
			mb_q  <= mul_b;
			acc_q <= '0;
		end else if (mul_busy_q) begin
			pp_s1   <= pp_c;
			ppsh_s1 <= ppsh_c;
			if (ppv_s1) acc_q <= acc_q + ({64'b0, pp_s1} << {ppsh_s1, 5'b0});
		end
	end

	always_comb begin
		div_start = 1'b1;
		div_num   = '0;
		div_den   = '0;
		unique case (cmd.op)
			OP_RDIV: begin div_num = {3'b0, hm_q, 31'b0}; div_den = {2'b0, h_q[cmd.idx_i]}; end
			OP_DIV2: begin div_num = {2'b0, b_q} + {2'b0, root_q}; div_den = a_q; end
			default: div_start = 1'b0;
		endcase
	end

	assign div_sh   = {drem_q, dnum_q[65]};
	assign div_ge   = div_sh >= {1'b0, dden_q};
	assign div_diff = div_sh - {1'b0, dden_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			dcnt_q     <= 7'd66;
		end else if (div_busy_q) begin
			dcnt_q <= dcnt_q - 7'd1;
			if (dcnt_q == 7'd1) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			dnum_q <= div_num;
			dden_q <= div_den;
			drem_q <= '0;
			quo_q  <= '0;
		end else if (div_busy_q) begin
			dnum_q <= {dnum_q[64:0], 1'b0};
			drem_q <= div_ge ? div_diff[33:0] : div_sh[33:0];
			quo_q  <= {quo_q[64:0], div_ge};
		end
	end

	assign sq_start = (cmd.op == OP_SQRT);
	assign sq_rad   = p_q - msum_q;
	assign sq_sh    = {srem_q, rad_q[127:126]};
	assign sq_trial = {2'b0, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_diff  = sq_sh - sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			scnt_q    <= '0;
		end else if (sq_start) begin
			sq_busy_q <= 1'b1;
			scnt_q    <= 7'd64;
		end else if (sq_busy_q) begin
			scnt_q <= scnt_q - 7'd1;
			if (scnt_q == 7'd1) sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sq_start) begin
			rad_q  <= sq_rad;
			root_q <= '0;
			srem_q <= '0;
		end else if (sq_busy_q) begin
			rad_q  <= {rad_q[125:0], 2'b00};
			srem_q <= sq_ge ? sq_diff[65:0] : sq_sh[65:0];
			root_q <= {root_q[62:0], sq_ge};
		end
	end

	assign stat.busy   = mul_busy_q | div_busy_q | sq_busy_q;
	assign stat.skip   = t_q[0] > cfg.neighbour_limit;
	assign stat.gt1    = cand_q > t_q[1];
	assign stat.k_more = (q_q[47:31] != '0) | d_q[0][31] | d_q[1][31] | d_q[2][31];
	assign stat.fail   = p_q < msum_q;
	assign stat.go3    = !(cand_q < t_q[2]) && (t_q[2] != FAR);

	assign res.skipped  = skip_q;
	assign res.updated  = !skip_q && (cand_q < cur_q);
	assign res.new_time = res.updated ? cand_q : cur_q;

endmodule
`default_nettype wire

// ===== rtl/eik_ctrl.sv =====
// Controller of the eikonal node update: sequences the neighbour-limit skip, one-sided
// estimate and two- and three-axis solves through the datapath. Depends on eik_pkg.
`default_nettype none
module eik_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           out_free,
	input  wire eik_pkg::stat_t stat,
	output eik_pkg::cmd_t       cmd
);
	import eik_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SORT  = 5'd1;
	localparam logic [4:0] ST_CHECK = 5'd2;
	localparam logic [4:0] ST_WAIT  = 5'd3;
	localparam logic [4:0] ST_ONE   = 5'd4;
	localparam logic [4:0] ST_CMP1  = 5'd5;
	localparam logic [4:0] ST_SETUP = 5'd6;
	localparam logic [4:0] ST_QD    = 5'd7;
	localparam logic [4:0] ST_K     = 5'd8;
	localparam logic [4:0] ST_RDIV  = 5'd9;
	localparam logic [4:0] ST_RSQ   = 5'd10;
	localparam logic [4:0] ST_U     = 5'd11;
	localparam logic [4:0] ST_B     = 5'd12;
	localparam logic [4:0] ST_QQ    = 5'd13;
	localparam logic [4:0] ST_P1    = 5'd14;
	localparam logic [4:0] ST_P2    = 5'd15;
	localparam logic [4:0] ST_UU    = 5'd16;
	localparam logic [4:0] ST_DD    = 5'd17;
	localparam logic [4:0] ST_PR    = 5'd18;
	localparam logic [4:0] ST_MS    = 5'd19;
	localparam logic [4:0] ST_CHK   = 5'd20;
	localparam logic [4:0] ST_DIV2  = 5'd21;
	localparam logic [4:0] ST_CAND  = 5'd22;
	localparam logic [4:0] ST_NEXT  = 5'd23;
	localparam logic [4:0] ST_FIN   = 5'd24;

	logic [4:0] state_q, state_d, ret_q, ret_d;
	logic       n3_q, n3_d;
	logic [1:0] i_q, i_d, pair_q, pair_d;
	logic [1:0] pi, pj;

	assign pi       = (pair_q == 2'd2) ? 2'd1 : 2'd0;
	assign pj       = (pair_q == 2'd0) ? 2'd1 : 2'd2;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.op    = OP_NONE;
		cmd.n3    = n3_q;
		cmd.idx_i = i_q;
		cmd.idx_j = i_q;
		state_d   = state_q;
		ret_d     = ret_q;
		n3_d      = n3_q;
		i_d       = i_q;
		pair_d    = pair_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				cmd.op  = OP_SORT;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.skip) begin
					cmd.op  = OP_SKIP;
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_MUL_SH0;
					ret_d   = ST_ONE;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!stat.busy) state_d = ret_q;
			end
			ST_ONE: begin
				cmd.op  = OP_ONESIDE;
				state_d = ST_CMP1;
			end
			ST_CMP1: begin
				n3_d    = 1'b0;
				state_d = stat.gt1 ? ST_SETUP : ST_FIN;
			end
			ST_SETUP: begin
				cmd.op  = OP_SETUP;
				ret_d   = ST_QD;
				state_d = ST_WAIT;
			end
			ST_QD: begin
				cmd.op  = OP_QD;
				state_d = ST_K;
			end
			ST_K: begin
				if (stat.k_more) begin
					cmd.op = OP_KSTEP;
				end else begin
					i_d     = 2'd0;
					state_d = ST_RDIV;
				end
			end
			ST_RDIV: begin
				cmd.op  = OP_RDIV;
				ret_d   = ST_RSQ;
				state_d = ST_WAIT;
			end
			ST_RSQ: begin
				cmd.op  = OP_RSQ;
				ret_d   = ST_U;
				state_d = ST_WAIT;
			end
			ST_U: begin
				cmd.op  = OP_U;
				ret_d   = ST_B;
				state_d = ST_WAIT;
			end
			ST_B: begin
				cmd.op = OP_B;
				if (i_q == (n3_q ? 2'd2 : 2'd1)) begin
					state_d = ST_QQ;
				end else begin
					i_d     = i_q + 2'd1;
					state_d = ST_RDIV;
				end
			end
			ST_QQ: begin
				cmd.op  = OP_QQ;
				ret_d   = ST_P1;
				state_d = ST_WAIT;
			end
			ST_P1: begin
				cmd.op  = OP_P1;
				ret_d   = ST_P2;
				state_d = ST_WAIT;
			end
			ST_P2: begin
				cmd.op  = OP_P2;
				pair_d  = 2'd0;
				state_d = ST_UU;
			end
			ST_UU: begin
				cmd.op    = OP_UU;
				cmd.idx_i = pi;
				cmd.idx_j = pj;
				ret_d     = ST_DD;
				state_d   = ST_WAIT;
			end
			ST_DD: begin
				cmd.op    = OP_DD;
				cmd.idx_i = pi;
				cmd.idx_j = pj;
				ret_d     = ST_PR;
				state_d   = ST_WAIT;
			end
			ST_PR: begin
				cmd.op  = OP_PR;
				ret_d   = ST_MS;
				state_d = ST_WAIT;
			end
			ST_MS: begin
				cmd.op = OP_MS;
				if (n3_q && pair_q != 2'd2) begin
					pair_d  = pair_q + 2'd1;
					state_d = ST_UU;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.fail) begin
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_SQRT;
					ret_d   = ST_DIV2;
					state_d = ST_WAIT;
				end
			end
			ST_DIV2: begin
				cmd.op  = OP_DIV2;
				ret_d   = ST_CAND;
				state_d = ST_WAIT;
			end
			ST_CAND: begin
				cmd.op  = OP_CAND;
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (!n3_q && stat.go3) begin
					n3_d    = 1'b1;
					state_d = ST_SETUP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.op  = OP_DELIVER;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			n3_q    <= 1'b0;
			i_q     <= '0;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			n3_q    <= n3_d;
			i_q     <= i_d;
			pair_q  <= pair_d;
		end
	end

endmodule
`default_nettype wire
